// ----- sv/fwup_pkg.sv -----
`timescale 1ns / 1ps
package fwup_pkg;

  localparam int CHUNK_BYTES = 256;
  localparam int CHUNK_W     = $clog2(CHUNK_BYTES + 1);
  localparam int MAGIC_LEN   = 5;
  localparam int MAX_RES     = 3;
  localparam int CNT_W       = $clog2(MAX_RES + 1);

  localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;
  localparam logic [7:0]  ACK_MAGIC      = 8'hAA;
  localparam logic [7:0]  ACK_CHUNK      = 8'h55;
  localparam logic [15:0] TIMEOUT_RST    = 16'd15000;
  localparam logic [19:0] MAX_IMAGE_RST  = 20'd458752;
  localparam logic [31:0] IMAGE_BASE_RST = 32'h08010000;

  localparam logic [1:0] CFG_TIMEOUT    = 2'd0;
  localparam logic [1:0] CFG_MAX_IMAGE  = 2'd1;
  localparam logic [1:0] CFG_IMAGE_BASE = 2'd2;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_SIZE,
    PH_CRC,
    PH_ERASE,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_TICK,
    CMD_ERASE_RES,
    CMD_PROG_FAIL
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_ERASE,
    KIND_WRITE,
    KIND_DONE
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TIMEOUT,
    ST_BAD_MAGIC,
    ST_BAD_SIZE,
    ST_ERASE_FAIL,
    ST_PROG_FAIL,
    ST_CRC_MISMATCH
  } status_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] rx_byte;
    logic       erase_ok;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic [31:0] flash_addr;
    logic [31:0] flash_word;
    status_t     status;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]   count;
  } grp_t;

  function automatic res_t mk_res(kind_t kind, logic [7:0] tx, logic [31:0] addr,
                                  logic [31:0] word, status_t st);
    res_t r;
    r.kind       = kind;
    r.tx_byte    = tx;
    r.flash_addr = addr;
    r.flash_word = word;
    r.status     = st;
    return r;
  endfunction

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  function automatic logic [7:0] magic_byte(logic [2:0] idx);
    logic [7:0] m;
    case (idx)
      3'd0: m = 8'h53;
      3'd1: m = 8'h54;
      3'd2: m = 8'h41;
      3'd3: m = 8'h52;
      3'd4: m = 8'h54;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// ----- sv/fwup_ifs.sv -----
`timescale 1ns / 1ps
interface fwup_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;
  logic       erase_ok;

  modport source(output valid, cmd, rx_byte, erase_ok, input ready);
  modport sink(input valid, cmd, rx_byte, erase_ok, output ready);
endinterface

interface fwup_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [31:0] flash_addr;
  logic [31:0] flash_word;
  logic [2:0]  status;
  logic        last;

  modport source(output valid, kind, tx_byte, flash_addr, flash_word, status, last,
                 input ready);
  modport sink(input valid, kind, tx_byte, flash_addr, flash_word, status, last,
               output ready);
endinterface

// ----- sv/firmware_upload_receiver.sv -----
`timescale 1ns / 1ps
// channel  dir  beat payload
// item     in   cmd, rx_byte, erase_ok
// result   out  kind, tx_byte, flash_addr, flash_word, status, last
// cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// an item waits in the input register until the result buffer is free, then its
// results are loaded into the result buffer
// one item per cycle while each item gives at most one result and the sink is
// ready; an item with k results holds the single result port for k beats
// synchronous active-high reset, no clearing pass
// the input register takes a beat only while empty or advancing, so it stalls while results wait on a stalled sink
module firmware_upload_receiver (
  input  logic        clk,
  input  logic        rst,
  fwup_in_if.sink     item,
  fwup_out_if.source  result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic            iv;
  logic            free;
  logic            advance;
  fwup_pkg::item_t it;
  fwup_pkg::grp_t  grp;

  assign advance = iv && free;

  fwup_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .advance (advance),
    .iv      (iv),
    .it      (it)
  );

  fwup_step u_step (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .it        (it),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .grp       (grp)
  );

  fwup_res_buf u_buf (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .grp_in (grp),
    .free   (free),
    .result (result)
  );

endmodule

// ----- sv/fwup_in_stage.sv -----
`timescale 1ns / 1ps
module fwup_in_stage (
  input  logic            clk,
  input  logic            rst,
  fwup_in_if.sink         item,
  input  logic            advance,
  output logic            iv,
  output fwup_pkg::item_t it
);

  logic take;

  assign item.ready = !iv || advance;
  assign take       = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (take) begin
      iv <= 1'b1;
    end else if (advance) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      it.cmd      <= fwup_pkg::cmd_t'(item.cmd);
      it.rx_byte  <= item.rx_byte;
      it.erase_ok <= item.erase_ok;
    end
  end

endmodule

// ----- sv/fwup_step.sv -----
`timescale 1ns / 1ps
module fwup_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  fwup_pkg::item_t it,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  output fwup_pkg::grp_t  grp
);

  localparam int CW = fwup_pkg::CHUNK_W;

  logic [15:0] timeout_ticks;
  logic [19:0] max_image_bytes;
  logic [31:0] image_base;

  fwup_pkg::phase_t phase, phase_next;
  logic [2:0]    header_count, header_count_next;
  logic          magic_match, magic_match_next;
  logic [31:0]   image_size, image_size_next;
  logic [31:0]   expected_crc, expected_crc_next;
  logic [19:0]   bytes_left, bytes_left_next;
  logic [CW-1:0] chunk_left, chunk_left_next;
  logic [31:0]   running_crc, running_crc_next;
  logic [23:0]   word_buffer, word_buffer_next;
  logic [1:0]    byte_lane, byte_lane_next;
  logic [31:0]   write_addr, write_addr_next;
  logic [15:0]   timeout_count, timeout_count_next;

  logic [fwup_pkg::CNT_W-1:0] n;
  logic [7:0]                 b;
  logic                       mm;
  logic [31:0]                pad_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks   <= fwup_pkg::TIMEOUT_RST;
      max_image_bytes <= fwup_pkg::MAX_IMAGE_RST;
      image_base      <= fwup_pkg::IMAGE_BASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fwup_pkg::CFG_TIMEOUT:    timeout_ticks   <= cfg_data[15:0];
        fwup_pkg::CFG_MAX_IMAGE:  max_image_bytes <= cfg_data[19:0];
        fwup_pkg::CFG_IMAGE_BASE: image_base      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= fwup_pkg::PH_MAGIC;
      header_count  <= '0;
      magic_match   <= 1'b1;
      image_size    <= '0;
      expected_crc  <= '0;
      bytes_left    <= '0;
      chunk_left    <= '0;
      running_crc   <= fwup_pkg::CRC_INIT;
      word_buffer   <= '0;
      byte_lane     <= '0;
      write_addr    <= fwup_pkg::IMAGE_BASE_RST;
      timeout_count <= '0;
    end else if (go) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      magic_match   <= magic_match_next;
      image_size    <= image_size_next;
      expected_crc  <= expected_crc_next;
      bytes_left    <= bytes_left_next;
      chunk_left    <= chunk_left_next;
      running_crc   <= running_crc_next;
      word_buffer   <= word_buffer_next;
      byte_lane     <= byte_lane_next;
      write_addr    <= write_addr_next;
      timeout_count <= timeout_count_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    magic_match_next   = magic_match;
    image_size_next    = image_size;
    expected_crc_next  = expected_crc;
    bytes_left_next    = bytes_left;
    chunk_left_next    = chunk_left;
    running_crc_next   = running_crc;
    word_buffer_next   = word_buffer;
    byte_lane_next     = byte_lane;
    write_addr_next    = write_addr;
    timeout_count_next = timeout_count;
    grp                = '0;
    n                  = '0;
    b                  = it.rx_byte;
    mm                 = magic_match;
    pad_word           = '0;

    case (phase)
      fwup_pkg::PH_MAGIC, fwup_pkg::PH_SIZE, fwup_pkg::PH_CRC, fwup_pkg::PH_DATA: begin
        case (it.cmd)
          fwup_pkg::CMD_BYTE: begin
            if (phase == fwup_pkg::PH_DATA) begin
              if (byte_lane == 2'd3) begin
                grp.res[n] = fwup_pkg::mk_res(fwup_pkg::KIND_WRITE, 8'd0, write_addr_next,
                                              {b, word_buffer}, fwup_pkg::ST_OK);
                n = n + 1'b1;
                write_addr_next  = write_addr_next + 32'd4;
                word_buffer_next = '0;
                byte_lane_next   = '0;
              end else begin
                case (byte_lane)
                  2'd0:    word_buffer_next = {word_buffer[23:8], b};
                  2'd1:    word_buffer_next = {word_buffer[23:16], b, word_buffer[7:0]};
                  default: word_buffer_next = {b, word_buffer[15:0]};
                endcase
                byte_lane_next = byte_lane + 2'd1;
              end
              running_crc_next = fwup_pkg::crc_byte(running_crc, b);
              if (bytes_left != '0) bytes_left_next = bytes_left - 20'd1;
              if (chunk_left != '0) chunk_left_next = chunk_left - 1'b1;
              if (chunk_left_next == '0) begin
                if (byte_lane_next != 2'd0) begin
                  case (byte_lane_next)
                    2'd1:    pad_word = {24'hFFFFFF, word_buffer_next[7:0]};
                    2'd2:    pad_word = {16'hFFFF, word_buffer_next[15:0]};
                    default: pad_word = {8'hFF, word_buffer_next[23:0]};
                  endcase
                  grp.res[n] = fwup_pkg::mk_res(fwup_pkg::KIND_WRITE, 8'd0, write_addr_next,
                                                pad_word, fwup_pkg::ST_OK);
                  n = n + 1'b1;
                  write_addr_next  = write_addr_next + 32'd4;
                  word_buffer_next = '0;
                  byte_lane_next   = '0;
                end
                grp.res[n] = fwup_pkg::mk_res(fwup_pkg::KIND_BYTE, fwup_pkg::ACK_CHUNK, 32'd0,
                                              32'd0, fwup_pkg::ST_OK);
                n = n + 1'b1;
                if (bytes_left_next == '0) begin
                  grp.res[n] = fwup_pkg::mk_res(fwup_pkg::KIND_DONE, 8'd0, 32'd0, 32'd0,
                                 (~running_crc_next == expected_crc) ?
                                 fwup_pkg::ST_OK : fwup_pkg::ST_CRC_MISMATCH);
                  n = n + 1'b1;
                  phase_next = fwup_pkg::PH_DONE;
                end else begin
                  chunk_left_next = (bytes_left_next > 20'(fwup_pkg::CHUNK_BYTES)) ?
                                    CW'(fwup_pkg::CHUNK_BYTES) : CW'(bytes_left_next);
                  timeout_count_next = '0;
                end
              end
            end else if (phase == fwup_pkg::PH_MAGIC) begin
              if (b != fwup_pkg::magic_byte(header_count)) mm = 1'b0;
              magic_match_next = mm;
              if (header_count >= 3'(fwup_pkg::MAGIC_LEN - 1)) begin
                if (mm) begin
                  grp.res[n] = fwup_pkg::mk_res(fwup_pkg::KIND_BYTE, fwup_pkg::ACK_MAGIC,
                                                32'd0, 32'd0, fwup_pkg::ST_OK);
                  n = n + 1'b1;
                  phase_next         = fwup_pkg::PH_SIZE;
                  header_count_next  = '0;
                  timeout_count_next = '0;
                end else begin
                  grp.res[n] = fwup_pkg::mk_res(fwup_pkg::KIND_DONE, 8'd0, 32'd0, 32'd0,
                                                fwup_pkg::ST_BAD_MAGIC);
                  n = n + 1'b1;
                  phase_next = fwup_pkg::PH_DONE;
                end
              end else begin
                header_count_next = header_count + 3'd1;
              end
            end else begin
              if (phase == fwup_pkg::PH_SIZE) begin
                image_size_next = {b, image_size[31:8]};
              end else begin
                expected_crc_next = {b, expected_crc[31:8]};
              end
              if (header_count >= 3'd3) begin
                header_count_next  = '0;
                timeout_count_next = '0;
                if (phase == fwup_pkg::PH_SIZE) begin
                  phase_next = fwup_pkg::PH_CRC;
                end else if (image_size == '0 || image_size > {12'd0, max_image_bytes}) begin
                  grp.res[n] = fwup_pkg::mk_res(fwup_pkg::KIND_DONE, 8'd0, 32'd0, 32'd0,
                                                fwup_pkg::ST_BAD_SIZE);
                  n = n + 1'b1;
                  phase_next = fwup_pkg::PH_DONE;
                end else begin
                  grp.res[n] = fwup_pkg::mk_res(fwup_pkg::KIND_ERASE, 8'd0, 32'd0, 32'd0,
                                                fwup_pkg::ST_OK);
                  n = n + 1'b1;
                  phase_next = fwup_pkg::PH_ERASE;
                end
              end else begin
                header_count_next = header_count + 3'd1;
              end
            end
          end
          fwup_pkg::CMD_TICK: begin
            if (timeout_count != 16'hFFFF) timeout_count_next = timeout_count + 16'd1;
            if (timeout_count_next >= timeout_ticks) begin
              grp.res[n] = fwup_pkg::mk_res(fwup_pkg::KIND_DONE, 8'd0, 32'd0, 32'd0,
                                            fwup_pkg::ST_TIMEOUT);
              n = n + 1'b1;
              phase_next = fwup_pkg::PH_DONE;
            end
          end
          fwup_pkg::CMD_PROG_FAIL: begin
            if (phase == fwup_pkg::PH_DATA) begin
              grp.res[n] = fwup_pkg::mk_res(fwup_pkg::KIND_DONE, 8'd0, 32'd0, 32'd0,
                                            fwup_pkg::ST_PROG_FAIL);
              n = n + 1'b1;
              phase_next = fwup_pkg::PH_DONE;
            end
          end
          default: ;
        endcase
      end
      fwup_pkg::PH_ERASE: begin
        if (it.cmd == fwup_pkg::CMD_ERASE_RES) begin
          if (it.erase_ok) begin
            phase_next         = fwup_pkg::PH_DATA;
            bytes_left_next    = image_size[19:0];
            running_crc_next   = fwup_pkg::CRC_INIT;
            word_buffer_next   = '0;
            byte_lane_next     = '0;
            write_addr_next    = image_base;
            chunk_left_next    = (image_size[19:0] > 20'(fwup_pkg::CHUNK_BYTES)) ?
                                 CW'(fwup_pkg::CHUNK_BYTES) : CW'(image_size[19:0]);
            timeout_count_next = '0;
            if (image_size[19:0] == '0) begin
              grp.res[n] = fwup_pkg::mk_res(fwup_pkg::KIND_DONE, 8'd0, 32'd0, 32'd0,
                                            fwup_pkg::ST_BAD_SIZE);
              n = n + 1'b1;
              phase_next = fwup_pkg::PH_DONE;
            end
          end else begin
            grp.res[n] = fwup_pkg::mk_res(fwup_pkg::KIND_DONE, 8'd0, 32'd0, 32'd0,
                                          fwup_pkg::ST_ERASE_FAIL);
            n = n + 1'b1;
            phase_next = fwup_pkg::PH_DONE;
          end
        end
      end
      default: ;
    endcase

    grp.count = n;
  end

endmodule

// ----- sv/fwup_res_buf.sv -----
`timescale 1ns / 1ps
module fwup_res_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  fwup_pkg::grp_t grp_in,
  output logic           free,
  fwup_out_if.source     result
);

  localparam int CW = fwup_pkg::CNT_W;

  fwup_pkg::res_t [fwup_pkg::MAX_RES-1:0] res;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          last;
  logic          pop;
  fwup_pkg::res_t cur;

  assign cur  = res[idx[$clog2(fwup_pkg::MAX_RES)-1:0]];
  assign last = (idx == count - 1'b1);
  assign pop  = result.valid && result.ready;
  assign free = (count == '0) || (pop && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else if (load) begin
      count <= grp_in.count;
      idx   <= '0;
    end else if (pop) begin
      if (last) begin
        count <= '0;
        idx   <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= grp_in.res;
    end
  end

  assign result.valid      = (count != '0);
  assign result.kind       = cur.kind;
  assign result.tx_byte    = cur.tx_byte;
  assign result.flash_addr = cur.flash_addr;
  assign result.flash_word = cur.flash_word;
  assign result.status     = cur.status;
  assign result.last       = last;

endmodule
